[hw/rtl/pdr_pkg.sv]
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared types, number formats and codes of the delta-rule perceptron neuron.
// ----------------------------------------------------------------------------
package pdr_pkg;

  // Number formats
  localparam int FEAT_W     = 16;             // Q4.12 feature, target, output
  localparam int WGT_W      = 24;             // Q12.12 weight and bias
  localparam int FRAC_W     = 12;
  localparam int PROD_W     = FEAT_W + WGT_W; // feature * weight, Q.24
  localparam int ACC_W      = PROD_W + 4;     // room for eight products plus bias
  localparam int Z_W        = ACC_W - FRAC_W; // sum rounded to Q.12
  localparam int LEAK_W     = Z_W + 11;       // z * leaky slope
  localparam int R2E_W      = 34;             // 2 * rate * error, Q.28
  localparam int UPD_W      = R2E_W + FEAT_W; // step * feature, Q.40
  localparam int MAX_INPUTS = 8;
  localparam int IDX_W      = 4;
  localparam int RATE_W     = 16;
  localparam int BAND_W     = 15;
  localparam int CFG_IDX_W  = 2;

  localparam logic signed [10:0] LEAKY_Q16 = 11'sd655;  // 0.01 in Q0.16
  localparam logic signed [Z_W-1:0] ONE_Q12 = Z_W'(4096);

  // Request codes
  localparam logic [1:0] REQ_INFER = 2'd0;
  localparam logic [1:0] REQ_TRAIN = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;

  // Activation codes
  localparam logic [1:0] ACT_LINEAR = 2'd0;
  localparam logic [1:0] ACT_RELU   = 2'd1;
  localparam logic [1:0] ACT_LEAKY  = 2'd2;
  localparam logic [1:0] ACT_STEP   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATION_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCURACY_BAND   = 2'd2;

  localparam logic [IDX_W-1:0] BIAS_INDEX = 4'd8;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd6554;
  localparam logic [BAND_W-1:0] BAND_RESET = 15'd410;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [FEAT_W-1:0] feature_0;
    logic signed [FEAT_W-1:0] feature_1;
    logic signed [FEAT_W-1:0] feature_2;
    logic signed [FEAT_W-1:0] feature_3;
    logic signed [FEAT_W-1:0] feature_4;
    logic signed [FEAT_W-1:0] feature_5;
    logic signed [FEAT_W-1:0] feature_6;
    logic signed [FEAT_W-1:0] feature_7;
    logic signed [FEAT_W-1:0] target_value;
    logic [IDX_W-1:0]        weight_index;
    logic signed [WGT_W-1:0]  weight_value;
  } in_item_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] output_value;
    logic signed [FEAT_W-1:0] error_value;
    logic                    within_band;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [RATE_W-1:0]    value;
  } cfg_item_t;

  // Sequencer strobes to the lanes
  typedef struct packed {
    logic mul_en;
    logic upd_en;
  } lane_ctrl_t;

  // Saturate a Q.12 value to 16 bits
  function automatic logic signed [FEAT_W-1:0] sat_q412(input logic signed [Z_W-1:0] v);
    if (v > Z_W'(32767)) begin
      return 16'sh7fff;
    end else if (v < -Z_W'(32768)) begin
      return 16'sh8000;
    end else begin
      return v[FEAT_W-1:0];
    end
  endfunction

  // Saturate a 25-bit sum to a 24-bit weight
  function automatic logic signed [WGT_W-1:0] sat_wgt(input logic signed [WGT_W:0] v);
    if (v[WGT_W] != v[WGT_W-1]) begin
      return v[WGT_W] ? {1'b1, {(WGT_W-1){1'b0}}} : {1'b0, {(WGT_W-1){1'b1}}};
    end else begin
      return v[WGT_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/pdr_stream_if.sv]
// ----------------------------------------------------------------------------
// pdr_stream_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface pdr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/pdr_lane.sv]
// ----------------------------------------------------------------------------
// pdr_lane
// One weight lane: holds a weight, forms feature * weight, applies its update.
// ----------------------------------------------------------------------------
module pdr_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pdr_pkg::lane_ctrl_t                ctrl_i,
  input  logic                               wr_en_i,
  input  logic signed [pdr_pkg::WGT_W-1:0]   wr_val_i,
  input  logic signed [pdr_pkg::FEAT_W-1:0]  feat_i,
  input  logic signed [pdr_pkg::R2E_W-1:0]   rate2e_i,
  output logic signed [pdr_pkg::PROD_W-1:0]  prod_o
);

  logic signed [pdr_pkg::WGT_W-1:0]  w_q, w_d;
  logic signed [pdr_pkg::PROD_W-1:0] prod_q;
  logic signed [pdr_pkg::UPD_W-1:0]  upd_prod;
  logic signed [pdr_pkg::UPD_W-1:0]  upd_rnd;
  logic signed [pdr_pkg::UPD_W-29:0] upd_step;
  logic signed [pdr_pkg::WGT_W:0]    w_sum;

  // Delta step rounded half up from Q.40 to Q.12, then saturated add
  always_comb begin
    upd_prod = rate2e_i * feat_i;
    upd_rnd  = upd_prod + (pdr_pkg::UPD_W'(1) <<< 27);
    upd_step = $signed(upd_rnd[pdr_pkg::UPD_W-1:28]);
    w_sum    = pdr_pkg::WGT_W'(0) + w_q + upd_step;
    w_d      = w_q;
    if (wr_en_i) begin
      w_d = wr_val_i;
    end else if (ctrl_i.upd_en) begin
      w_d = pdr_pkg::sat_wgt(w_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else begin
      w_q <= w_d;
    end
  end

  // Product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= feat_i * w_q;
    end
  end

  assign prod_o = prod_q;

endmodule

[hw/rtl/pdr_merge.sv]
// ----------------------------------------------------------------------------
// pdr_merge
// Adds the lane products and the bias into the registered dot product.
// ----------------------------------------------------------------------------
module pdr_merge #(
  parameter int N_INPUTS = 8
) (
  input  logic                              clk_i,
  input  logic                              sum_en_i,
  input  logic signed [pdr_pkg::PROD_W-1:0] prod_i [N_INPUTS],
  input  logic signed [pdr_pkg::WGT_W-1:0]  bias_i,
  output logic signed [pdr_pkg::ACC_W-1:0]  acc_o
);

  logic signed [pdr_pkg::ACC_W-1:0] sum;
  logic signed [pdr_pkg::ACC_W-1:0] acc_q;

  // Bias in Q.24 plus every lane product
  always_comb begin
    sum = $signed({{(pdr_pkg::ACC_W-pdr_pkg::WGT_W-pdr_pkg::FRAC_W){bias_i[pdr_pkg::WGT_W-1]}},
                   bias_i, {pdr_pkg::FRAC_W{1'b0}}});
    for (int i = 0; i < N_INPUTS; i++) begin
      sum = sum + pdr_pkg::ACC_W'(prod_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      acc_q <= sum;
    end
  end

  assign acc_o = acc_q;

endmodule

[hw/rtl/perceptron_delta_rule_neuron.sv]
// ----------------------------------------------------------------------------
// perceptron_delta_rule_neuron
// Single neuron with stored weights and bias, inference and delta-rule update.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  carries one request per transaction: infer, train or load. Load
//          writes one weight (index 0..7) or the bias (index 8) and returns
//          nothing; infer and train return one transaction on rsp_o.
//   rsp_o  output, error (target minus output) and the within-band flag.
//   cfg_i  register writes (learning rate, activation, band); write only
//          while the block is idle. cfg_i is always ready.
// Sequence:
//   A load is done in the idle state, which stays ready. Infer steps through
//   lane multiply, lane merge, activation and output, each registered, and
//   the next request is taken once the sequencer is back in idle. Train adds
//   an update step that applies the weight update. The steps run as a serial
//   chain, which all go through the one set of stored weights.
// Reset: weights and bias clear to zero, registers take their defaults.
// Stall: a result waits in the output register while the next request is
//   accepted; the sequencer holds in its output step until the register frees.
// ----------------------------------------------------------------------------
module perceptron_delta_rule_neuron #(
  parameter int N_INPUTS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pdr_stream_if.sink   cfg_i,
  pdr_stream_if.sink   req_i,
  pdr_stream_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_ACT, S_OUT, S_UPD
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [pdr_pkg::RATE_W-1:0] rate_q;
  logic [1:0]                 act_q;
  logic [pdr_pkg::BAND_W-1:0] band_q;

  // Captured request
  logic [1:0]                        req_q;
  logic signed [pdr_pkg::FEAT_W-1:0] feat_q [N_INPUTS];
  logic signed [pdr_pkg::FEAT_W-1:0] target_q;
  logic signed [pdr_pkg::FEAT_W-1:0] feat_in [pdr_pkg::MAX_INPUTS];

  logic signed [pdr_pkg::WGT_W-1:0]  bias_q;
  logic signed [pdr_pkg::PROD_W-1:0] prod [N_INPUTS];
  logic signed [pdr_pkg::ACC_W-1:0]  acc;
  logic signed [pdr_pkg::ACC_W-1:0]  acc_rnd;
  logic signed [pdr_pkg::Z_W-1:0]    z, z_q;
  logic signed [pdr_pkg::LEAK_W-1:0] leak_q, leak_rnd;
  logic signed [pdr_pkg::Z_W-1:0]    leak_y;
  logic signed [pdr_pkg::Z_W-1:0]    y_pre;
  logic signed [pdr_pkg::FEAT_W-1:0] y_sat, err_sat;
  logic signed [pdr_pkg::FEAT_W:0]   err_full;
  logic [pdr_pkg::FEAT_W:0]          err_mag;
  logic signed [pdr_pkg::R2E_W-2:0]  re_prod;
  logic signed [pdr_pkg::R2E_W-1:0]  rate2e_q;
  logic signed [pdr_pkg::R2E_W-1:0]  b_rnd;
  logic signed [pdr_pkg::R2E_W-17:0] b_step;
  logic signed [pdr_pkg::WGT_W:0]    b_sum;

  pdr_pkg::out_item_t  rsp_q;
  logic                rsp_valid_q;
  pdr_pkg::lane_ctrl_t lane_ctrl;
  logic                req_acc;
  logic                load_acc;
  logic                out_free;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign req_acc     = req_i.valid && req_i.ready;
  assign load_acc    = req_acc && (req_i.data.req_type == pdr_pkg::REQ_LOAD);
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  assign feat_in[0] = req_i.data.feature_0;
  assign feat_in[1] = req_i.data.feature_1;
  assign feat_in[2] = req_i.data.feature_2;
  assign feat_in[3] = req_i.data.feature_3;
  assign feat_in[4] = req_i.data.feature_4;
  assign feat_in[5] = req_i.data.feature_5;
  assign feat_in[6] = req_i.data.feature_6;
  assign feat_in[7] = req_i.data.feature_7;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= pdr_pkg::RATE_RESET;
      act_q  <= pdr_pkg::ACT_LINEAR;
      band_q <= pdr_pkg::BAND_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        pdr_pkg::CFG_LEARNING_RATE:   rate_q <= cfg_i.data.value;
        pdr_pkg::CFG_ACTIVATION_MODE: act_q  <= cfg_i.data.value[1:0];
        pdr_pkg::CFG_ACCURACY_BAND:   band_q <= cfg_i.data.value[pdr_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_q    <= req_i.data.req_type;
      target_q <= req_i.data.target_value;
      for (int i = 0; i < N_INPUTS; i++) begin
        feat_q[i] <= feat_in[i];
      end
    end
  end

  assign lane_ctrl.mul_en = (state_q == S_MUL);
  assign lane_ctrl.upd_en = (state_q == S_UPD);

  // Weight lanes
  for (genvar g = 0; g < N_INPUTS; g++) begin : g_lane
    pdr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .wr_en_i  (load_acc && (req_i.data.weight_index == pdr_pkg::IDX_W'(g))),
      .wr_val_i (req_i.data.weight_value),
      .feat_i   (feat_q[g]),
      .rate2e_i (rate2e_q),
      .prod_o   (prod[g])
    );
  end

  pdr_merge #(
    .N_INPUTS (N_INPUTS)
  ) u_merge (
    .clk_i    (clk_i),
    .sum_en_i (state_q == S_SUM),
    .prod_i   (prod),
    .bias_i   (bias_q),
    .acc_o    (acc)
  );

  // Round the dot product to Q.12
  assign acc_rnd = acc + pdr_pkg::ACC_W'(2048);
  assign z       = $signed(acc_rnd[pdr_pkg::ACC_W-1:pdr_pkg::FRAC_W]);

  // Activation, error and band check
  always_comb begin
    leak_rnd = leak_q + pdr_pkg::LEAK_W'(32768);
    leak_y   = pdr_pkg::Z_W'($signed(leak_rnd[pdr_pkg::LEAK_W-1:16]));
    case (act_q)
      pdr_pkg::ACT_RELU:  y_pre = (z_q > 0) ? z_q : '0;
      pdr_pkg::ACT_LEAKY: y_pre = (z_q > 0) ? z_q : leak_y;
      pdr_pkg::ACT_STEP:  y_pre = (z_q > 0) ? pdr_pkg::ONE_Q12 : '0;
      default:            y_pre = z_q;
    endcase
    y_sat    = pdr_pkg::sat_q412(y_pre);
    err_full = target_q - y_sat;
    err_sat  = pdr_pkg::sat_q412(pdr_pkg::Z_W'(err_full));
    err_mag  = err_sat[pdr_pkg::FEAT_W-1] ? -(pdr_pkg::FEAT_W+1)'(err_sat)
                                          : (pdr_pkg::FEAT_W+1)'(err_sat);
    re_prod  = $signed({1'b0, rate_q}) * err_sat;
  end

  // Bias step rounded half up from Q.28 to Q.12
  always_comb begin
    b_rnd  = rate2e_q + pdr_pkg::R2E_W'(32768);
    b_step = $signed(b_rnd[pdr_pkg::R2E_W-1:16]);
    b_sum  = pdr_pkg::WGT_W'(0) + bias_q + b_step;
  end

  // Sequencer, bias and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      bias_q      <= '0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (load_acc && (req_i.data.weight_index == pdr_pkg::BIAS_INDEX)) begin
            bias_q <= req_i.data.weight_value;
          end
          if (req_acc && (req_i.data.req_type == pdr_pkg::REQ_INFER ||
                          req_i.data.req_type == pdr_pkg::REQ_TRAIN)) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_SUM;
        S_SUM: state_q <= S_ACT;
        S_ACT: begin
          z_q     <= z;
          leak_q  <= z * pdr_pkg::LEAKY_Q16;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            rsp_q.output_value <= y_sat;
            rsp_q.error_value  <= err_sat;
            rsp_q.within_band  <= (err_mag < (pdr_pkg::FEAT_W+1)'(band_q));
            rate2e_q           <= {re_prod, 1'b0};
            state_q            <= (req_q == pdr_pkg::REQ_TRAIN) ? S_UPD : S_IDLE;
          end
        end
        S_UPD: begin
          bias_q  <= pdr_pkg::sat_wgt(b_sum);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/pdr_checker.sv]
// ----------------------------------------------------------------------------
// pdr_checker
// Port-level checks of the neuron's request and result channels.
// ----------------------------------------------------------------------------
module pdr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [1:0]         in_req_type_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input pdr_pkg::out_item_t out_data_i
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // A load leaves the block ready in the next cycle
  a_load_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_req_type_i == pdr_pkg::REQ_LOAD |=> in_ready_i)
    else $error("not ready after a load transaction");

  // An infer or train transaction occupies the block
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i &&
    (in_req_type_i == pdr_pkg::REQ_INFER || in_req_type_i == pdr_pkg::REQ_TRAIN)
    |=> !in_ready_i)
    else $error("ready while computing");

  // A new result only comes out of a busy block
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result without a computation");

endmodule

bind perceptron_delta_rule_neuron pdr_checker u_pdr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .in_req_type_i (req_i.data.req_type),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .out_data_i    (rsp_o.data)
);

[test/tb_perceptron_delta_rule_neuron.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_perceptron_delta_rule_neuron
// Self-checking bench for the delta-rule neuron. A directed table covers
// field extremes, rounding, saturation, ignored loads and the reserved
// request; random phases then sweep the learning rate, activation and band.
// Each response is compared against the table's value or a fixed-point model.
// ----------------------------------------------------------------------------
module tb_perceptron_delta_rule_neuron;

  localparam int N_INPUTS      = 8;
  localparam int N_PHASES      = 8;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PRINT_LIMIT   = 40;

  localparam logic [1:0]                    REQ_RESERVED = 2'd3;
  localparam logic [pdr_pkg::CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_SPARSE} sink_style_e;

  typedef struct {
    pdr_pkg::in_item_t  item;
    bit                 typed;
    pdr_pkg::out_item_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  pdr_stream_if #(.T(pdr_pkg::cfg_item_t)) cfg_if ();
  pdr_stream_if #(.T(pdr_pkg::in_item_t))  req_if ();
  pdr_stream_if #(.T(pdr_pkg::out_item_t)) rsp_if ();

  perceptron_delta_rule_neuron #(.N_INPUTS(N_INPUTS)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Model state of the neuron
  logic signed [pdr_pkg::WGT_W-1:0]  nrn_weight [pdr_pkg::MAX_INPUTS];
  logic signed [pdr_pkg::WGT_W-1:0]  nrn_bias;
  logic        [pdr_pkg::RATE_W-1:0] nrn_rate;
  logic        [1:0]                 nrn_act;
  logic        [pdr_pkg::BAND_W-1:0] nrn_band;

  pdr_pkg::out_item_t pending_outputs [$];
  dir_row_t           dir_rows [$];
  int unsigned        error_count  = 0;
  int unsigned        cycle_count  = 0;
  bit                 hold_pending = 1'b0;
  int                 burst_left   = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: cycle limit reached, %0d results outstanding", pending_outputs.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic longint clamp_signed(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Neuron response to one request; updates the model state. Returns 1 when
  // the request produces a response.
  function automatic bit neuron_response(input pdr_pkg::in_item_t it,
                                         output pdr_pkg::out_item_t res);
    longint feat [pdr_pkg::MAX_INPUTS];
    longint acc, z, y, err, mag, step2e;
    int     i;
    res = '0;
    if (it.req_type == pdr_pkg::REQ_LOAD) begin
      if (it.weight_index < pdr_pkg::BIAS_INDEX) begin
        nrn_weight[it.weight_index[2:0]] = it.weight_value;
      end else if (it.weight_index == pdr_pkg::BIAS_INDEX) begin
        nrn_bias = it.weight_value;
      end
      return 1'b0;
    end
    if (it.req_type != pdr_pkg::REQ_INFER && it.req_type != pdr_pkg::REQ_TRAIN) begin
      return 1'b0;
    end
    feat[0] = longint'($signed(it.feature_0));
    feat[1] = longint'($signed(it.feature_1));
    feat[2] = longint'($signed(it.feature_2));
    feat[3] = longint'($signed(it.feature_3));
    feat[4] = longint'($signed(it.feature_4));
    feat[5] = longint'($signed(it.feature_5));
    feat[6] = longint'($signed(it.feature_6));
    feat[7] = longint'($signed(it.feature_7));

    // Exact Q.24 sum, then round to Q.12
    acc = longint'(nrn_bias) <<< pdr_pkg::FRAC_W;
    for (i = 0; i < N_INPUTS; i++) begin
      acc += feat[i] * longint'(nrn_weight[i]);
    end
    z = round_half_up(acc, pdr_pkg::FRAC_W);

    case (nrn_act)
      pdr_pkg::ACT_RELU:  y = (z > 0) ? z : 0;
      pdr_pkg::ACT_LEAKY: y = (z > 0) ? z : round_half_up(z * longint'(pdr_pkg::LEAKY_Q16), 16);
      pdr_pkg::ACT_STEP:  y = (z > 0) ? longint'(pdr_pkg::ONE_Q12) : 0;
      default:            y = z;
    endcase
    y   = clamp_signed(y, pdr_pkg::FEAT_W);
    err = clamp_signed(longint'($signed(it.target_value)) - y, pdr_pkg::FEAT_W);
    mag = (err < 0) ? -err : err;

    res.output_value = pdr_pkg::FEAT_W'(y);
    res.error_value  = pdr_pkg::FEAT_W'(err);
    res.within_band  = (mag < longint'(nrn_band));

    // Delta rule: step is Q.28, step*feature Q.40, both rounded to Q12.12
    if (it.req_type == pdr_pkg::REQ_TRAIN) begin
      step2e = 2 * longint'(nrn_rate) * err;
      for (i = 0; i < N_INPUTS; i++) begin
        nrn_weight[i] = pdr_pkg::WGT_W'(clamp_signed(longint'(nrn_weight[i]) +
                                                     round_half_up(step2e * feat[i], 28),
                                                     pdr_pkg::WGT_W));
      end
      nrn_bias = pdr_pkg::WGT_W'(clamp_signed(longint'(nrn_bias) + round_half_up(step2e, 16),
                                              pdr_pkg::WGT_W));
    end
    return 1'b1;
  endfunction

  function automatic pdr_pkg::in_item_t make_req(
      input logic [1:0]                        rq,
      input logic signed [pdr_pkg::FEAT_W-1:0] f_lo,
      input logic signed [pdr_pkg::FEAT_W-1:0] f_hi,
      input logic signed [pdr_pkg::FEAT_W-1:0] tgt,
      input logic [pdr_pkg::IDX_W-1:0]         idx,
      input logic signed [pdr_pkg::WGT_W-1:0]  wv);
    pdr_pkg::in_item_t it;
    it.req_type     = rq;
    it.feature_0    = f_lo;
    it.feature_1    = f_lo;
    it.feature_2    = f_lo;
    it.feature_3    = f_lo;
    it.feature_4    = f_hi;
    it.feature_5    = f_hi;
    it.feature_6    = f_hi;
    it.feature_7    = f_hi;
    it.target_value = tgt;
    it.weight_index = idx;
    it.weight_value = wv;
    return it;
  endfunction

  task automatic add_row(input pdr_pkg::in_item_t it, input bit typed,
                         input pdr_pkg::out_item_t want);
    dir_row_t r;
    r.item  = it;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  function automatic logic signed [pdr_pkg::FEAT_W-1:0] rand_feat(input bit wide);
    if (wide) return pdr_pkg::FEAT_W'($urandom_range(0, 65535));
    return pdr_pkg::FEAT_W'($urandom_range(0, 8192)) - pdr_pkg::FEAT_W'(4096);
  endfunction

  // Random request with every field filled
  function automatic pdr_pkg::in_item_t rand_req(input bit wide);
    pdr_pkg::in_item_t it;
    it.req_type     = 2'($urandom_range(0, 3));
    it.feature_0    = rand_feat(wide);
    it.feature_1    = rand_feat(wide);
    it.feature_2    = rand_feat(wide);
    it.feature_3    = rand_feat(wide);
    it.feature_4    = rand_feat(wide);
    it.feature_5    = rand_feat(wide);
    it.feature_6    = rand_feat(wide);
    it.feature_7    = rand_feat(wide);
    it.target_value = rand_feat(wide);
    it.weight_index = pdr_pkg::IDX_W'($urandom_range(0, 15));
    if (wide) begin
      it.weight_value = pdr_pkg::WGT_W'($urandom());
    end else begin
      it.weight_value = pdr_pkg::WGT_W'($urandom_range(0, 16384)) - pdr_pkg::WGT_W'(8192);
    end
    return it;
  endfunction

  // Register write; leaves valid high so back-to-back writes need one NBA
  task automatic write_reg(input logic [pdr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pdr_pkg::RATE_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= pdr_pkg::cfg_item_t'{idx, val};
    do @(negedge clk_i); while (!cfg_if.ready);
    @(posedge clk_i);
    case (idx)
      pdr_pkg::CFG_LEARNING_RATE:   nrn_rate = val;
      pdr_pkg::CFG_ACTIVATION_MODE: nrn_act  = val[1:0];
      pdr_pkg::CFG_ACCURACY_BAND:   nrn_band = val[pdr_pkg::BAND_W-1:0];
      default: ;
    endcase
  endtask

  // Predict, queue the expectation and offer the request until accepted.
  // Sender runs in bursts with gaps between them when gaps is set.
  task automatic offer_request(input pdr_pkg::in_item_t it, input bit typed,
                               input pdr_pkg::out_item_t want, input bit gaps);
    pdr_pkg::out_item_t pred;
    int                 gap;
    if (neuron_response(it, pred)) begin
      pending_outputs.push_back(typed ? want : pred);
    end
    if (gaps && burst_left <= 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(negedge clk_i); while (!req_if.ready);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while (pending_outputs.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Response sink: the stall style changes at random intervals; a hold
  // request closes it for a long stretch.
  initial begin : rsp_sink
    sink_style_e style;
    int          style_left;
    int          hold_left;
    int          tick;
    style      = SINK_OPEN;
    style_left = 0;
    hold_left  = 0;
    tick       = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (style_left <= 0) begin
        style      = sink_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(32, 256);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (style)
          SINK_OPEN:   rsp_if.ready <= 1'b1;
          SINK_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY: rsp_if.ready <= (tick % 4) != 0;
          default:     rsp_if.ready <= (tick % 5) == 0;
        endcase
      end
    end
  end

  // Response check, sampled mid-cycle when the handshake signals are stable
  always @(negedge clk_i) begin : rsp_check
    pdr_pkg::out_item_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_outputs.size() == 0) begin
        report_error($sformatf("unexpected response out=%0d err=%0d band=%0b",
                               rsp_if.data.output_value, rsp_if.data.error_value,
                               rsp_if.data.within_band));
      end else begin
        want = pending_outputs.pop_front();
        if (rsp_if.data.output_value !== want.output_value) begin
          report_error($sformatf("output_value got %0d want %0d",
                                 $signed(rsp_if.data.output_value), $signed(want.output_value)));
        end
        if (rsp_if.data.error_value !== want.error_value) begin
          report_error($sformatf("error_value got %0d want %0d",
                                 $signed(rsp_if.data.error_value), $signed(want.error_value)));
        end
        if (rsp_if.data.within_band !== want.within_band) begin
          report_error($sformatf("within_band got %0b want %0b",
                                 rsp_if.data.within_band, want.within_band));
        end
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    pdr_pkg::in_item_t          it;
    pdr_pkg::in_item_t          seq_base;
    int                         seq_left;
    int                         p;
    int                         n;
    int                         sel;
    bit                         wide;
    bit                         use_gaps;
    logic [pdr_pkg::RATE_W-1:0] rate;
    logic [pdr_pkg::BAND_W-1:0] band;
    logic [1:0]                 act_order [4];

    act_order = '{pdr_pkg::ACT_LINEAR, pdr_pkg::ACT_RELU, pdr_pkg::ACT_LEAKY,
                  pdr_pkg::ACT_STEP};
    seq_left  = 0;
    seq_base  = '0;

    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;

    // Model reset state
    foreach (nrn_weight[i]) nrn_weight[i] = '0;
    nrn_bias = '0;
    nrn_rate = pdr_pkg::RATE_RESET;
    nrn_act  = pdr_pkg::ACT_LINEAR;
    nrn_band = pdr_pkg::BAND_RESET;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, default registers, all weights zero at the start
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh7fff, 16'sh8000, 16'sh0000, 4'd0, 24'sh0), 1'b1,
            pdr_pkg::out_item_t'{16'sh0000, 16'sh0000, 1'b1});
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh8000, 16'sh7fff, 16'sh7fff, 4'd0, 24'sh0), 1'b1,
            pdr_pkg::out_item_t'{16'sh0000, 16'sh7fff, 1'b0});
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh0000, 16'sh0000, 16'sh8000, 4'd0, 24'sh0), 1'b1,
            pdr_pkg::out_item_t'{16'sh0000, 16'sh8000, 1'b0});
    // band edge: 409 inside, 410 outside
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh0000, 16'sh0000, 16'sh0199, 4'd0, 24'sh0), 1'b1,
            pdr_pkg::out_item_t'{16'sh0000, 16'sh0199, 1'b1});
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh0000, 16'sh0000, 16'sh019a, 4'd0, 24'sh0), 1'b1,
            pdr_pkg::out_item_t'{16'sh0000, 16'sh019a, 1'b0});
    // rounding at exactly one half LSB, both signs
    add_row(make_req(pdr_pkg::REQ_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 4'd0, 24'sh000001),
            1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh0800, 16'sh0000, 16'sh0000, 4'd0, 24'sh0), 1'b1,
            pdr_pkg::out_item_t'{16'sh0001, 16'shffff, 1'b1});
    add_row(make_req(pdr_pkg::REQ_INFER, 16'shf800, 16'sh0000, 16'sh0000, 4'd0, 24'sh0), 1'b1,
            pdr_pkg::out_item_t'{16'sh0000, 16'sh0000, 1'b1});
    add_row(make_req(pdr_pkg::REQ_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 4'd0, 24'sh000000),
            1'b0, '0);
    // bias extremes saturate output and error
    add_row(make_req(pdr_pkg::REQ_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, pdr_pkg::BIAS_INDEX,
                     24'sh7fffff), 1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh0000, 16'sh0000, 16'sh8000, 4'd0, 24'sh0), 1'b1,
            pdr_pkg::out_item_t'{16'sh7fff, 16'sh8000, 1'b0});
    add_row(make_req(pdr_pkg::REQ_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, pdr_pkg::BIAS_INDEX,
                     24'sh800000), 1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh0000, 16'sh0000, 16'sh7fff, 4'd0, 24'sh0), 1'b1,
            pdr_pkg::out_item_t'{16'sh8000, 16'sh7fff, 1'b0});
    // out-of-range load index and reserved request change nothing
    add_row(make_req(pdr_pkg::REQ_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 4'd9, 24'sh123456),
            1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_LOAD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 4'd15, 24'sh7fffff),
            1'b0, '0);
    add_row(make_req(REQ_RESERVED, 16'sh7fff, 16'sh8000, 16'sh7fff, 4'd8, 24'sh7fffff),
            1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh0000, 16'sh0000, 16'sh0000, 4'd0, 24'sh0), 1'b1,
            pdr_pkg::out_item_t'{16'sh8000, 16'sh7fff, 1'b0});
    add_row(make_req(pdr_pkg::REQ_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, pdr_pkg::BIAS_INDEX,
                     24'sh000000), 1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 4'd0, 24'sh001000),
            1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 4'd7, 24'shfff000),
            1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh1000, 16'sh0000, 16'sh0000, 4'd0, 24'sh0), 1'b1,
            pdr_pkg::out_item_t'{16'sh1000, 16'shf000, 1'b0});
    // training, checked by the model
    add_row(make_req(pdr_pkg::REQ_TRAIN, 16'sh1000, 16'sh0800, 16'sh2000, 4'd0, 24'sh0),
            1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_TRAIN, 16'sh1000, 16'sh0800, 16'sh2000, 4'd0, 24'sh0),
            1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh0800, 16'sh1000, 16'sh0000, 4'd0, 24'sh0),
            1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_LOAD, 16'sh0000, 16'sh0000, 16'sh0000, 4'd3, 24'sh7fffff),
            1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_TRAIN, 16'sh7fff, 16'sh8000, 16'sh7fff, 4'd0, 24'sh0),
            1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_TRAIN, 16'sh8000, 16'sh7fff, 16'sh8000, 4'd0, 24'sh0),
            1'b0, '0);
    add_row(make_req(pdr_pkg::REQ_INFER, 16'sh7fff, 16'sh7fff, 16'sh0000, 4'd0, 24'sh0),
            1'b0, '0);

    foreach (dir_rows[k]) begin
      offer_request(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want, 1'b1);
    end
    req_if.valid <= 1'b0;

    // Random phases, each with its own register setting
    for (p = 0; p < N_PHASES; p++) begin
      wait_drained();
      if (p == 1) begin
        rate = '0;
      end else if (p == 2) begin
        rate = '1;
      end else begin
        rate = pdr_pkg::RATE_W'($urandom_range(0, 16384));
      end
      if (p == 3) begin
        band = '0;
      end else if (p == 4) begin
        band = '1;
      end else begin
        band = pdr_pkg::BAND_W'($urandom_range(0, 4096));
      end
      write_reg(pdr_pkg::CFG_LEARNING_RATE, rate);
      write_reg(pdr_pkg::CFG_ACTIVATION_MODE, pdr_pkg::RATE_W'(act_order[p % 4]));
      write_reg(pdr_pkg::CFG_ACCURACY_BAND, pdr_pkg::RATE_W'(band));
      if (p == 5) begin
        write_reg(CFG_SPARE, pdr_pkg::RATE_W'($urandom()));
      end
      cfg_if.valid <= 1'b0;

      // phase 2 fills the block against a closed sink; phase 6 runs back-to-back
      use_gaps = (p != 2) && (p != 6);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 10) begin
          hold_pending = 1'b1;
        end
        if (seq_left > 0) begin
          it          = seq_base;
          it.req_type = ($urandom_range(0, 4) == 0) ? pdr_pkg::REQ_INFER : pdr_pkg::REQ_TRAIN;
          seq_left--;
        end else begin
          sel  = $urandom_range(0, 99);
          wide = ($urandom_range(0, 3) == 0);
          it   = rand_req(wide);
          if (sel < 20) begin
            it.req_type     = pdr_pkg::REQ_LOAD;
            it.weight_index = pdr_pkg::IDX_W'($urandom_range(0, 8));
          end else if (sel < 50) begin
            it.req_type = pdr_pkg::REQ_INFER;
          end else if (sel < 70) begin
            it.req_type = pdr_pkg::REQ_TRAIN;
          end else if (sel < 90) begin
            // repeated training on one pattern
            it.req_type = pdr_pkg::REQ_TRAIN;
            seq_base    = it;
            seq_left    = $urandom_range(3, 8);
          end else if (sel < 95) begin
            it.req_type     = pdr_pkg::REQ_LOAD;
            it.weight_index = pdr_pkg::IDX_W'($urandom_range(9, 15));
          end else begin
            it.req_type = REQ_RESERVED;
          end
        end
        offer_request(it, 1'b0, '0, use_gaps);
      end
      req_if.valid <= 1'b0;
    end

    wait_drained();
    if (pending_outputs.size() != 0) begin
      report_error($sformatf("%0d expected responses never arrived", pending_outputs.size()));
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pdr_pkg.sv
hw/rtl/pdr_stream_if.sv
hw/rtl/pdr_lane.sv
hw/rtl/pdr_merge.sv
hw/rtl/perceptron_delta_rule_neuron.sv
hw/rtl/pdr_checker.sv
test/tb_perceptron_delta_rule_neuron.sv
